[design/aep_pkg.sv]
// Package for the ARM ELF relocation patcher: request and result types,
// relocation kind, symbol class and status codes. No dependencies.
package aep_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CodeW = 3;

  localparam logic [CodeW-1:0] OP_NONE   = 3'd0;
  localparam logic [CodeW-1:0] OP_ABS32  = 3'd1;
  localparam logic [CodeW-1:0] OP_BRANCH = 3'd2;
  localparam logic [CodeW-1:0] OP_MOVW   = 3'd3;
  localparam logic [CodeW-1:0] OP_MOVT   = 3'd4;
  localparam logic [CodeW-1:0] OP_V4BX   = 3'd5;

  localparam logic [CodeW-1:0] CLS_SECTION  = 3'd0;
  localparam logic [CodeW-1:0] CLS_UNDEF    = 3'd1;
  localparam logic [CodeW-1:0] CLS_COMMON   = 3'd2;
  localparam logic [CodeW-1:0] CLS_ABS      = 3'd3;
  localparam logic [CodeW-1:0] CLS_ABS_BASE = 3'd4;

  localparam logic [CodeW-1:0] ST_PATCHED = 3'd0;
  localparam logic [CodeW-1:0] ST_SKIPPED = 3'd1;
  localparam logic [CodeW-1:0] ST_UNDEF   = 3'd2;
  localparam logic [CodeW-1:0] ST_COMMON  = 3'd3;
  localparam logic [CodeW-1:0] ST_UNKNOWN = 3'd4;

  localparam logic [WordW-1:0] BaseSymAddr = 32'd4;

  typedef struct packed {
    logic [CodeW-1:0] op;
    logic [CodeW-1:0] symbol_class;
    logic [WordW-1:0] symbol_value;
    logic [WordW-1:0] section_base;
    logic [WordW-1:0] target_word;
    logic [WordW-1:0] place_address;
  } aep_req_t;

  typedef struct packed {
    logic [WordW-1:0] patched_word;
    logic [CodeW-1:0] status;
  } aep_rsp_t;

endpackage

[design/aep_patch.sv]
// Combinational relocation datapath: symbol address, branch, MOVW/MOVT and
// ABS32 patching, status decode. Depends on aep_pkg.
module aep_patch import aep_pkg::*; (
  input  aep_req_t         req_i,
  input  logic [WordW-1:0] virt_offset_i,
  output aep_rsp_t         rsp_o
);

  logic [WordW-1:0] sym_addr;
  logic [WordW-1:0] voff;
  logic [WordW-1:0] abs_word;
  logic [25:0]      br_off;
  logic [WordW-1:0] br_word;
  logic [WordW-1:0] mov_sum;
  logic [15:0]      mov_imm;
  logic [WordW-1:0] mov_word;
  logic [WordW-1:0] w;

  assign w = req_i.target_word;

  always_comb begin
    voff = virt_offset_i;
    case (req_i.symbol_class)
      CLS_ABS:      sym_addr = req_i.symbol_value;
      CLS_ABS_BASE: begin
        sym_addr = BaseSymAddr;
        voff     = '0;
      end
      default:      sym_addr = req_i.section_base + req_i.symbol_value;
    endcase
  end

  assign abs_word = w + sym_addr + voff;

  assign br_off  = {w[23:0], 2'b00} + sym_addr[25:0] - req_i.place_address[25:0];
  assign br_word = {w[31:24], br_off[25:2]};

  assign mov_sum  = {{16{w[19]}}, w[19:16], w[11:0]} + sym_addr + voff;
  assign mov_imm  = (req_i.op == OP_MOVT) ? mov_sum[31:16] : mov_sum[15:0];
  assign mov_word = {w[31:20], mov_imm[15:12], w[15:12], mov_imm[11:0]};

  always_comb begin
    rsp_o.patched_word = w;
    rsp_o.status       = ST_PATCHED;
    if (req_i.op == OP_V4BX) begin
      rsp_o.status = ST_SKIPPED;
    end else if (req_i.symbol_class == CLS_UNDEF) begin
      rsp_o.status = ST_UNDEF;
    end else if (req_i.symbol_class == CLS_COMMON) begin
      rsp_o.status = ST_COMMON;
    end else begin
      case (req_i.op)
        OP_NONE:   rsp_o.patched_word = w;
        OP_ABS32:  rsp_o.patched_word = abs_word;
        OP_BRANCH: rsp_o.patched_word = br_word;
        OP_MOVW:   rsp_o.patched_word = mov_word;
        OP_MOVT:   rsp_o.patched_word = mov_word;
        default:   rsp_o.status       = ST_UNKNOWN;
      endcase
    end
  end

endmodule

[design/arm_elf_relocation_patcher_unit.sv]
// Top level of the ARM ELF relocation patcher: request register, patch
// datapath, result register and the virtual offset register.
// Depends on aep_pkg and aep_patch.
//
//   channel  dir  handshake                 payload
//   in       in   in_valid_i / in_stall_o   in_req_i   (aep_req_t)
//   out      out  out_valid_o / out_stall_i out_rsp_o  (aep_rsp_t)
//   cfg      in   cfg_we_i                  cfg_wdata_i (virtual offset)
//
// One request per cycle while in_stall_o is low; an accepted request is patched
// from the request register and loaded into the result register, from which its
// result leaves when out_stall_i is low.
// Reset clears both valid flags and the virtual offset to zero.
// A stalled result holds the result register; the request register still
// fills while it is empty, so in_stall_o rises only when both stages are full.
module arm_elf_relocation_patcher_unit import aep_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  aep_req_t         in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output aep_rsp_t         out_rsp_o,
  input  logic             cfg_we_i,
  input  logic [WordW-1:0] cfg_wdata_i
);

  logic             req_valid_q, req_valid_d;
  aep_req_t         req_q;
  logic             rsp_valid_q, rsp_valid_d;
  aep_rsp_t         rsp_q;
  logic [WordW-1:0] voff_q;
  aep_rsp_t         rsp_d;
  logic             out_blocked;
  logic             req_adv;
  logic             in_acc;

  assign out_blocked = rsp_valid_q && out_stall_i;
  assign req_adv     = req_valid_q && !out_blocked;
  assign in_stall_o  = req_valid_q && out_blocked;
  assign in_acc      = in_valid_i && !in_stall_o;

  aep_patch u_patch (
    .req_i        (req_q),
    .virt_offset_i(voff_q),
    .rsp_o        (rsp_d)
  );

  always_comb begin
    req_valid_d = req_valid_q;
    if (in_acc) begin
      req_valid_d = 1'b1;
    end else if (req_adv) begin
      req_valid_d = 1'b0;
    end
    rsp_valid_d = rsp_valid_q;
    if (req_adv) begin
      rsp_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      voff_q      <= '0;
    end else begin
      req_valid_q <= req_valid_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        voff_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_req_i;
    end
    if (req_adv) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = rsp_valid_q;
  assign out_rsp_o   = rsp_q;

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_valid_q |-> !in_stall_o)
    else $error("request stalled with empty request register");

  a_adv_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_adv |=> out_valid_o)
    else $error("advanced request produced no result");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q |-> rsp_d.status <= ST_UNKNOWN)
    else $error("illegal status code");

  a_word_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && rsp_d.status != ST_PATCHED) |->
      rsp_d.patched_word == req_q.target_word)
    else $error("word changed on skip or error");

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(rsp_q)))
    else $error("stalled result changed");

endmodule

[test/tb_arm_elf_relocation_patcher_unit.sv]
// Testbench for arm_elf_relocation_patcher_unit: random and directed relocations,
// each checked against a relocation predictor held in a small scoreboard class.
// Depends on aep_pkg and the patcher RTL.
module tb_arm_elf_relocation_patcher_unit;
  import aep_pkg::*;

  localparam logic [CodeW-1:0] OP_OTHER    = 3'd6;
  localparam logic [CodeW-1:0] OP_RESERVED = 3'd7;
  localparam int unsigned      RandPerPhase = 125;
  localparam int unsigned      NumPhases    = 6;

  class relocation_scoreboard;
    logic [WordW-1:0] virt_offset;
    aep_rsp_t         pending_patches[$];
    int unsigned      errors;

    function new();
      virt_offset = '0;
      errors = 0;
    endfunction

    function aep_rsp_t apply_relocation(aep_req_t r);
      aep_rsp_t         rsp;
      logic [WordW-1:0] sym;
      logic [WordW-1:0] voff;
      logic [WordW-1:0] off;
      logic [WordW-1:0] imm;
      logic [15:0]      half;
      rsp.patched_word = r.target_word;
      rsp.status = ST_PATCHED;
      voff = virt_offset;
      if (r.op == OP_V4BX) begin
        rsp.status = ST_SKIPPED;
      end else if (r.symbol_class == CLS_UNDEF) begin
        rsp.status = ST_UNDEF;
      end else if (r.symbol_class == CLS_COMMON) begin
        rsp.status = ST_COMMON;
      end else begin
        if (r.symbol_class == CLS_ABS) begin
          sym = r.symbol_value;
        end else if (r.symbol_class == CLS_ABS_BASE) begin
          sym = BaseSymAddr;
          voff = '0;
        end else begin
          sym = r.section_base + r.symbol_value;
        end
        case (r.op)
          OP_NONE: begin
          end
          OP_ABS32: begin
            rsp.patched_word = r.target_word + sym + voff;
          end
          OP_BRANCH: begin
            off = {{6{r.target_word[23]}}, r.target_word[23:0], 2'b00} + sym - r.place_address;
            rsp.patched_word = {r.target_word[31:24], off[25:2]};
          end
          OP_MOVW, OP_MOVT: begin
            imm = {{16{r.target_word[19]}}, r.target_word[19:16], r.target_word[11:0]}
                  + sym + voff;
            half = (r.op == OP_MOVT) ? imm[31:16] : imm[15:0];
            rsp.patched_word = {r.target_word[31:20], half[15:12], r.target_word[15:12],
                                half[11:0]};
          end
          default: begin
            rsp.status = ST_UNKNOWN;
          end
        endcase
      end
      return rsp;
    endfunction

    task report_mismatch(string what, logic [WordW-1:0] got, logic [WordW-1:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    function void note_request(aep_req_t r);
      pending_patches.push_back(apply_relocation(r));
    endfunction

    task check_result(aep_rsp_t rsp);
      aep_rsp_t want;
      if (pending_patches.size() == 0) begin
        report_mismatch("result with no request pending", rsp.patched_word, '0);
      end else begin
        want = pending_patches.pop_front();
        if (rsp.patched_word !== want.patched_word)
          report_mismatch("patched_word", rsp.patched_word, want.patched_word);
        if (rsp.status !== want.status)
          report_mismatch("status", WordW'(rsp.status), WordW'(want.status));
      end
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  aep_req_t         in_req_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  aep_rsp_t         out_rsp_o;
  logic             cfg_we_i = 1'b0;
  logic [WordW-1:0] cfg_wdata_i = '0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  relocation_scoreboard sb = new();

  arm_elf_relocation_patcher_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= (rx_idle_pct != 0) && ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(in_req_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_rsp_o);
    end
  end

  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic aep_req_t make_request();
    aep_req_t    r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) r.op = OP_NONE;
    else if (pick < 28) r.op = OP_ABS32;
    else if (pick < 48) r.op = OP_BRANCH;
    else if (pick < 66) r.op = OP_MOVW;
    else if (pick < 84) r.op = OP_MOVT;
    else if (pick < 90) r.op = OP_V4BX;
    else if (pick < 95) r.op = OP_OTHER;
    else r.op = OP_RESERVED;
    pick = $urandom_range(99);
    if (pick < 35) r.symbol_class = CLS_SECTION;
    else if (pick < 60) r.symbol_class = CLS_ABS;
    else if (pick < 75) r.symbol_class = CLS_ABS_BASE;
    else if (pick < 83) r.symbol_class = CLS_UNDEF;
    else if (pick < 90) r.symbol_class = CLS_COMMON;
    else r.symbol_class = CodeW'($urandom_range(5, 7));
    r.symbol_value = pick_word();
    r.section_base = pick_word();
    r.target_word = pick_word();
    r.place_address = pick_word();
    return r;
  endfunction

  function automatic aep_req_t build_request(logic [CodeW-1:0] op, logic [CodeW-1:0] cls,
                                             logic [WordW-1:0] val, logic [WordW-1:0] base,
                                             logic [WordW-1:0] word, logic [WordW-1:0] place);
    aep_req_t r;
    r.op = op;
    r.symbol_class = cls;
    r.symbol_value = val;
    r.section_base = base;
    r.target_word = word;
    r.place_address = place;
    return r;
  endfunction

  task automatic send_request(aep_req_t r);
    while ((tx_idle_pct != 0) && ($urandom_range(99) < tx_idle_pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_requests();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_patches.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_virt_offset(logic [WordW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.virt_offset = value;
  endtask

  task automatic run_directed();
    logic [CodeW-1:0] code;
    for (int i = 0; i < 8; i++) begin
      code = CodeW'(i);
      send_request(build_request(code, CLS_SECTION, 32'h0000_1000, 32'h8000_0000,
                                 32'hea00_0010, 32'h8000_0400));
    end
    for (int i = 0; i < 8; i++) begin
      code = CodeW'(i);
      send_request(build_request(OP_ABS32, code, 32'hffff_fffc, 32'h0000_0010,
                                 32'h1234_5678, 32'h0000_0000));
    end
    send_request(build_request(OP_V4BX, CLS_UNDEF, '0, '0, 32'he12f_ff1e, '0));
    send_request(build_request(OP_V4BX, CLS_COMMON, '1, '1, '1, '1));
    send_request(build_request(OP_BRANCH, CLS_SECTION, '1, '1, '1, 32'hffff_fffc));
    send_request(build_request(OP_BRANCH, CLS_ABS, '0, '0, 32'heb80_0000, '1));
    send_request(build_request(OP_BRANCH, CLS_ABS_BASE, '0, '0, 32'heb7f_ffff, '0));
    send_request(build_request(OP_MOVW, CLS_ABS_BASE, '1, '1, 32'he308_0000, '0));
    send_request(build_request(OP_MOVT, CLS_ABS, 32'h7fff_ffff, '0, 32'he34f_0fff, '0));
    send_request(build_request(OP_MOVT, CLS_SECTION, '1, '1, '1, '1));
  endtask

  initial begin
    logic [WordW-1:0] offsets[NumPhases];
    offsets[0] = '1;
    offsets[1] = $urandom;
    offsets[2] = '0;
    offsets[3] = 32'h8000_0000;
    offsets[4] = $urandom;
    offsets[5] = 32'h0000_ffff;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int p = 0; p < NumPhases; p++) begin
      drain_requests();
      write_virt_offset(offsets[p]);
      if (p < 2) begin
        tx_idle_pct = 14;
        rx_idle_pct = 75;
      end else if (p < 4) begin
        tx_idle_pct = 75;
        rx_idle_pct = 14;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (int n = 0; n < RandPerPhase; n++) send_request(make_request());
    end
    drain_requests();
    rx_idle_pct = 0;
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_patches.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
